/* sv/ptbf_pkg.sv */
// shared constants, types and state encoding for the packed two-bit table fill block
`timescale 1ns / 1ps
`default_nettype none

package ptbf_pkg;

   // table geometry
   localparam int TABLE_WORDS = 4096;
   localparam int WORD_BITS   = 64;
   localparam int ADDR_W      = $clog2(TABLE_WORDS);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int BLOCK_BITS  = 3;   // 8 words to a block

   // request payload widths
   localparam int INDEX_W = 17;
   localparam int FIELD_W = 5;       // 32 fields to a word
   localparam int WORD_W  = INDEX_W - FIELD_W;
   localparam int SHIFT_W = FIELD_W + 1;

   // configuration register widths and indexes
   localparam int LEVEL_W  = 2;
   localparam int HEADER_W = 4;
   localparam int CSR_W    = 4;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_LEVEL  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_VALUE = 1'b1;

   // opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DEMOTE = 1'b1;

   // demote masks: low bit of every field, header fields left out on block heads
   localparam logic [WORD_BITS-1:0] MASK_PLAIN  = 64'h5555_5555_5555_5555;
   localparam logic [WORD_BITS-1:0] MASK_HEADER = 64'h5555_5555_5555_5550;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_CHECK,
      ST_HEAD_READ,
      ST_HEAD_CHECK,
      ST_DEMOTE
   } state_type;

endpackage

`default_nettype wire

/* sv/ptbf_ram.sv */
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module ptbf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/packed_two_bit_table_fill.sv */
// top level: packed two-bit entry table with insert and whole-table demote
`timescale 1ns / 1ps
`default_nettype none

// channel    ports                                   handshake
// ---------  --------------------------------------  ---------------------------------
// request    req_op, req_entry_index                 taken when start high, busy low
// response   rsp_newly_set                           rsp_valid strobe, one cycle
// csr        csr_index, csr_write_data               csr_write_enable, no wait
//
// after reset the table is swept to zero, one word a cycle, with busy high until all
// TABLE_WORDS (4096) words are cleared; csr writes are taken during the sweep.
// insert: when the entry is already set the response comes without a write; else the
// entry word is read, modified and written, then the block head word is read and its
// header written only when zero; a word index past the table is answered, no busy.
// demote: one word read and one written back per cycle over the whole table.
// inserts and demotes share the single ram port pair and the one 64-bit adder.
// the receiver cannot stall: each response is shown for exactly one cycle.

module packed_two_bit_table_fill (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_op,
   input  wire logic [ptbf_pkg::INDEX_W-1:0]  req_entry_index,
   // response
   output logic                               rsp_valid,
   output logic                               rsp_newly_set,
   // csr
   input  wire logic                          csr_write_enable,
   input  wire logic [ptbf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ptbf_pkg::CSR_W-1:0]    csr_write_data
);

   localparam int AW = ptbf_pkg::ADDR_W;
   localparam int DW = ptbf_pkg::WORD_BITS;

   // control state
   ptbf_pkg::state_type state_ff, state_in;
   logic [ptbf_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_set_ff, rsp_set_in;

   // config registers
   logic [ptbf_pkg::LEVEL_W-1:0]  write_level_ff;
   logic [ptbf_pkg::HEADER_W-1:0] header_value_ff;

   // latched request index
   logic [ptbf_pkg::INDEX_W-1:0] index_ff, index_in;

   // ram hookup
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [DW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [DW-1:0] ram_rdata;

   // shared adder
   logic [DW-1:0] add_b;
   logic [DW-1:0] add_sum;

   // request decode
   logic                          accept;
   logic [ptbf_pkg::WORD_W-1:0]   req_word;
   logic                          req_in_range;
   logic [ptbf_pkg::WORD_W-1:0]   cur_word;
   logic [ptbf_pkg::SHIFT_W-1:0]  cur_shift;
   logic [1:0]                    cur_field;
   logic [1:0]                    ins_value;
   logic [ptbf_pkg::HEADER_W-1:0] head_value;
   logic [AW-1:0]                 dem_addr;
   logic [DW-1:0]                 dem_mask;

   assign busy          = (state_ff != ptbf_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_newly_set = rsp_set_ff;

   assign accept       = start && !busy;
   assign req_word     = req_entry_index[ptbf_pkg::INDEX_W-1:ptbf_pkg::FIELD_W];
   assign req_in_range = (32'(req_word) < ptbf_pkg::TABLE_WORDS);

   assign cur_word  = index_ff[ptbf_pkg::INDEX_W-1:ptbf_pkg::FIELD_W];
   assign cur_shift = {index_ff[ptbf_pkg::FIELD_W-1:0], 1'b0};
   assign cur_field = 2'(ram_rdata >> cur_shift);

   // entry written is 3 - level mod 4, header is 1 + value mod 16
   assign ins_value  = 2'(2'd3 - write_level_ff);
   assign head_value = ptbf_pkg::HEADER_W'(header_value_ff + 1'b1);

   // demote writes back the word addressed in the previous cycle
   assign dem_addr = AW'(cnt_ff - 1'b1);
   assign dem_mask = (dem_addr[ptbf_pkg::BLOCK_BITS-1:0] == '0) ?
                     ptbf_pkg::MASK_HEADER : ptbf_pkg::MASK_PLAIN;

   assign add_sum = ram_rdata + add_b;

   // config writes, taken in any state
   always_ff @(posedge clock) begin
      if (reset) begin
         write_level_ff  <= '0;
         header_value_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ptbf_pkg::CSR_WRITE_LEVEL: begin
               write_level_ff <= csr_write_data[ptbf_pkg::LEVEL_W-1:0];
            end
            ptbf_pkg::CSR_HEADER_VALUE: begin
               header_value_ff <= csr_write_data[ptbf_pkg::HEADER_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptbf_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_set_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_set_ff   <= rsp_set_in;
      end
   end

   // payload latch
   always_ff @(posedge clock) begin
      index_ff <= index_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_set_in   = 1'b0;
      index_in     = index_ff;
      ram_we       = 1'b0;
      ram_waddr    = dem_addr;
      ram_wdata    = add_sum;
      ram_raddr    = cnt_ff[AW-1:0];
      add_b        = '0;

      unique case (state_ff)
         ptbf_pkg::ST_CLEAR: begin
            // zero sweep after reset
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[AW-1:0];
            ram_wdata = '0;
            if (cnt_ff == ptbf_pkg::CNT_W'(ptbf_pkg::TABLE_WORDS - 1)) begin
               cnt_in   = '0;
               state_in = ptbf_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ptbf_pkg::ST_IDLE: begin
            ram_raddr = AW'(req_word);
            if (accept) begin
               index_in = req_entry_index;
               cnt_in   = '0;
               if (req_op == ptbf_pkg::OP_DEMOTE) begin
                  state_in = ptbf_pkg::ST_DEMOTE;
               end else if (req_in_range) begin
                  state_in = ptbf_pkg::ST_INS_CHECK;
               end else begin
                  // word beyond the table: nothing written
                  rsp_valid_in = 1'b1;
               end
            end
         end

         ptbf_pkg::ST_INS_CHECK: begin
            // entry word is on the read port
            if (cur_field != 2'd0) begin
               rsp_valid_in = 1'b1;
               state_in     = ptbf_pkg::ST_IDLE;
            end else begin
               add_b     = DW'(ins_value) << cur_shift;
               ram_we    = 1'b1;
               ram_waddr = AW'(cur_word);
               state_in  = ptbf_pkg::ST_HEAD_READ;
            end
         end

         ptbf_pkg::ST_HEAD_READ: begin
            // block head read after the entry write has landed
            ram_raddr = AW'({cur_word[ptbf_pkg::WORD_W-1:ptbf_pkg::BLOCK_BITS],
                             ptbf_pkg::BLOCK_BITS'(0)});
            state_in  = ptbf_pkg::ST_HEAD_CHECK;
         end

         ptbf_pkg::ST_HEAD_CHECK: begin
            add_b     = DW'(head_value);
            ram_waddr = AW'({cur_word[ptbf_pkg::WORD_W-1:ptbf_pkg::BLOCK_BITS],
                             ptbf_pkg::BLOCK_BITS'(0)});
            ram_we    = (ram_rdata[ptbf_pkg::HEADER_W-1:0] == '0);
            rsp_valid_in = 1'b1;
            rsp_set_in   = 1'b1;
            state_in     = ptbf_pkg::ST_IDLE;
         end

         ptbf_pkg::ST_DEMOTE: begin
            // read word cnt, write back word cnt - 1
            add_b  = (ram_rdata ^ (ram_rdata >> 1)) & dem_mask;
            ram_we = (cnt_ff != '0);
            if (cnt_ff == ptbf_pkg::CNT_W'(ptbf_pkg::TABLE_WORDS)) begin
               cnt_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ptbf_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         default: begin
            state_in = ptbf_pkg::ST_IDLE;
         end
      endcase
   end

   ptbf_ram #(
      .WIDTH (DW),
      .DEPTH (ptbf_pkg::TABLE_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire
